// File: src/lte_pkg.sv
// Shared types and constants for the lowercase trie engine.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package lte_pkg;

  // Node pool and alphabet
  localparam int NODE_COUNT = 1024;
  localparam int ALPHABET   = 26;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int USED_W     = $clog2(NODE_COUNT + 1);
  localparam int SLOT_COUNT = NODE_COUNT * ALPHABET;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int CHAR_IDX_W = $clog2(ALPHABET);

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_Z = 8'(CHAR_A + ALPHABET - 1);

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PREFIX = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADCHAR = 2'd2
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_byte;
    logic       no_char;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic    found;
    status_e status;
  } out_rsp_t;

  // Classified request as it sits in the queue
  typedef struct packed {
    op_e                   op;
    logic                  no_char;
    logic                  last;
    logic                  bad_char;
    logic [CHAR_IDX_W-1:0] char_idx;
  } cmd_t;

  // Status from the back end to the front end
  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // Queue status toward the front end
  typedef struct packed {
    logic full;
  } q_stat_t;

endpackage

// File: src/lowercase_trie_engine_top.sv
// Lowercase trie engine, top level. Front end, command queue and back end.
// Depends on lte_pkg, lte_front, lte_queue, lte_back.
//
// A 26-way trie of lowercase words. Each request carries one character
// of a word plus an operation (insert, search, remove, prefix test); the
// request flagged last yields exactly one result (found, status). Back-end
// steps: a request that walks one character does the child table read,
// then the allocate/advance step; a walking request that also ends the
// word adds the end-mark read/write and the result step; a final request
// without a walk step does only those last two; a non-final request that
// skips the walk is only popped. The child-table read port serializes
// characters. After reset the child table and end marks are cleared one
// entry per cycle across all NODE_COUNT*26 slots (26624 at the default
// pool), and the input stalls for that whole pass. A two-entry queue lets
// requests land while the back end works, and the result register lets
// the back end keep walking while a result waits on the output.
module lowercase_trie_engine_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lte_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lte_pkg::out_rsp_t  out_rsp_o
);

  lte_pkg::back_stat_t back_stat;
  lte_pkg::q_stat_t    q_stat;
  lte_pkg::cmd_t       push_cmd;
  lte_pkg::cmd_t       head_cmd;
  logic                push;
  logic                q_valid;
  logic                q_pop;

  // classify and accept
  lte_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .back_stat_i (back_stat),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // decouples the two sides
  lte_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .q_stat_o (q_stat),
    .valid_o  (q_valid),
    .cmd_o    (head_cmd),
    .pop_i    (q_pop)
  );

  // trie walk, memories and result register
  lte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (head_cmd),
    .q_pop_o     (q_pop),
    .back_stat_o (back_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: src/lte_front.sv
// Front end: accepts requests and classifies the character byte.
// Depends on lte_pkg.
module lte_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lte_pkg::in_req_t     in_req_i,
  input  lte_pkg::back_stat_t  back_stat_i,
  input  lte_pkg::q_stat_t     q_stat_i,
  output logic                 push_o,
  output lte_pkg::cmd_t        cmd_o
);

  logic [7:0] offset;

  assign offset     = in_req_i.char_byte - lte_pkg::CHAR_A;
  assign in_stall_o = q_stat_i.full | back_stat_i.clearing;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    cmd_o.op       = in_req_i.op;
    cmd_o.no_char  = in_req_i.no_char;
    cmd_o.last     = in_req_i.last;
    cmd_o.bad_char = (in_req_i.char_byte < lte_pkg::CHAR_A) |
                     (in_req_i.char_byte > lte_pkg::CHAR_Z);
    cmd_o.char_idx = offset[lte_pkg::CHAR_IDX_W-1:0];
  end

endmodule

// File: src/lte_queue.sv
// Short FIFO of classified requests between front and back end.
// Depends on lte_pkg.
module lte_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lte_pkg::cmd_t     cmd_i,
  output lte_pkg::q_stat_t  q_stat_o,
  output logic              valid_o,
  output lte_pkg::cmd_t     cmd_o,
  input  logic              pop_i
);

  lte_pkg::cmd_t                    mem_q [lte_pkg::Q_DEPTH];
  logic [lte_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [lte_pkg::QCNT_W-1:0]       cnt_q;
  logic                             do_pop;

  localparam logic [lte_pkg::QPTR_W-1:0] PtrLast = lte_pkg::QPTR_W'(lte_pkg::Q_DEPTH - 1);

  assign valid_o       = (cnt_q != '0);
  assign q_stat_o.full = (cnt_q == lte_pkg::QCNT_W'(lte_pkg::Q_DEPTH));
  assign cmd_o         = mem_q[rd_ptr_q];
  assign do_pop        = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: src/lte_back.sv
// Back end: walks the trie, allocates nodes, keeps end marks, builds results.
// Holds the child table and end-mark memories. Depends on lte_pkg.
module lte_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  lte_pkg::cmd_t        cmd_i,
  output logic                 q_pop_o,
  output lte_pkg::back_stat_t  back_stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lte_pkg::out_rsp_t    out_rsp_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_MARK,
    S_RESULT
  } state_e;

  localparam int NW = lte_pkg::NODE_W;
  localparam int AW = lte_pkg::SLOT_AW;
  localparam int UW = lte_pkg::USED_W;

  state_e             state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [NW-1:0]      cursor_q, cursor_d;
  logic               missed_q, missed_d;
  lte_pkg::status_e   wstat_q, wstat_d;
  logic [UW-1:0]      used_q, used_d;
  lte_pkg::op_e       op_q, op_d;
  logic               last_q, last_d;
  logic [AW-1:0]      slot_q, slot_d;
  logic               out_valid_q, out_valid_d;
  lte_pkg::out_rsp_t  out_rsp_q, out_rsp_d;

  // memories
  logic [NW-1:0]      child_mem [lte_pkg::SLOT_COUNT];
  logic               mark_mem  [lte_pkg::NODE_COUNT];
  logic [NW-1:0]      child_rd_q;
  logic               mark_rd_q;

  logic               cw_en;
  logic [AW-1:0]      cw_addr;
  logic [NW-1:0]      cw_data;
  logic [AW-1:0]      cr_addr;
  logic               mw_en;
  logic [NW-1:0]      mw_addr;
  logic               mw_data;
  logic               step;
  logic               clean;

  assign cr_addr = AW'(cursor_q) * AW'(lte_pkg::ALPHABET) + AW'(cmd_i.char_idx);
  assign clean   = (wstat_q == lte_pkg::ST_OK) & ~missed_q;
  assign step    = ~cmd_i.no_char & (wstat_q == lte_pkg::ST_OK);

  assign back_stat_o.clearing = (state_q == S_CLEAR);
  assign out_valid_o          = out_valid_q;
  assign out_rsp_o            = out_rsp_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cursor_d    = cursor_q;
    missed_d    = missed_q;
    wstat_d     = wstat_q;
    used_d      = used_q;
    op_d        = op_q;
    last_d      = last_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    cw_en       = 1'b0;
    cw_addr     = clr_q;
    cw_data     = '0;
    mw_en       = 1'b0;
    mw_addr     = clr_q[NW-1:0];
    mw_data     = 1'b0;
    q_pop_o     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        cw_en = 1'b1;
        mw_en = (clr_q < AW'(lte_pkg::NODE_COUNT));
        if (clr_q == AW'(lte_pkg::SLOT_COUNT - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          op_d    = cmd_i.op;
          last_d  = cmd_i.last;
          slot_d  = cr_addr;
          state_d = cmd_i.last ? S_MARK : S_IDLE;
          if (step && cmd_i.bad_char) begin
            wstat_d = lte_pkg::ST_BADCHAR;
          end else if (step && !missed_q) begin
            // child read at cr_addr is in flight
            state_d = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        state_d = last_q ? S_MARK : S_IDLE;
        if (child_rd_q == '0) begin
          if (op_q != lte_pkg::OP_INSERT) begin
            missed_d = 1'b1;
          end else if (used_q == UW'(lte_pkg::NODE_COUNT)) begin
            wstat_d = lte_pkg::ST_FULL;
          end else begin
            cw_en    = 1'b1;
            cw_addr  = slot_q;
            cw_data  = used_q[NW-1:0];
            cursor_d = used_q[NW-1:0];
            used_d   = used_q + 1'b1;
          end
        end else begin
          cursor_d = child_rd_q;
        end
      end
      S_MARK: begin
        // mark read of cursor_q is in flight; update marks for insert/remove
        mw_addr = cursor_q;
        state_d = S_RESULT;
        if (op_q == lte_pkg::OP_INSERT && wstat_q == lte_pkg::ST_OK) begin
          mw_en   = 1'b1;
          mw_data = 1'b1;
        end else if (op_q == lte_pkg::OP_REMOVE && clean) begin
          mw_en   = 1'b1;
          mw_data = 1'b0;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_rsp_d.status = wstat_q;
          case (op_q)
            lte_pkg::OP_SEARCH: out_rsp_d.found = clean & mark_rd_q;
            lte_pkg::OP_PREFIX: out_rsp_d.found = clean;
            default:            out_rsp_d.found = 1'b0;
          endcase
          cursor_d = '0;
          missed_d = 1'b0;
          wstat_d  = lte_pkg::ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      missed_q    <= 1'b0;
      wstat_q     <= lte_pkg::ST_OK;
      used_q      <= UW'(1);
      op_q        <= lte_pkg::OP_INSERT;
      last_q      <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      missed_q    <= missed_d;
      wstat_q     <= wstat_d;
      used_q      <= used_d;
      op_q        <= op_d;
      last_q      <= last_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      out_rsp_q   <= out_rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      child_mem[cw_addr] <= cw_data;
    end
    child_rd_q <= child_mem[cr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mw_en) begin
      mark_mem[mw_addr] <= mw_data;
    end
    mark_rd_q <= mark_mem[cursor_q];
  end

endmodule

// File: src/lte_checker.sv
// Port-level checks for the lowercase trie engine, bound to the top level.
// Depends on lte_pkg and lowercase_trie_engine_top.
module lte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input lte_pkg::in_req_t   in_req_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lte_pkg::out_rsp_t  out_rsp_o
);

  // words in flight: queue, back end, result register
  localparam int PendMax = lte_pkg::Q_DEPTH + 2;
  localparam int PendW   = $clog2(PendMax + 2);

  logic [PendW-1:0] pend_q;
  logic             in_last_acc;
  logic             out_acc;

  assign in_last_acc = in_valid_i & ~in_stall_o & in_req_i.last;
  assign out_acc     = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_last_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (!in_last_acc && out_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found |-> out_rsp_o.status == lte_pkg::ST_OK)
    else $error("found set with error status");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != '0)
    else $error("result without a finished word");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendW'(PendMax))
    else $error("too many words in flight");

endmodule

bind lowercase_trie_engine_top lte_checker u_lte_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for lowercase_trie_engine_top: drives words one character
// per request and checks every result against a behavioral trie kept here.
// Depends on lte_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb;
  import lte_pkg::*;

  localparam int unsigned WATCHDOG = 100000;  // covers the post-reset clearing pass
  localparam int unsigned TAIL     = 30;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_req_t   in_req_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_rsp_t  out_rsp_o;

  lowercase_trie_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Trie mirror
  bit [NODE_W-1:0] kid_tbl [SLOT_COUNT];
  bit              word_end [NODE_COUNT];
  int unsigned     pool_used = 1;
  int unsigned     walk_node = 0;
  bit              walk_miss = 1'b0;
  status_e         walk_err  = ST_OK;

  out_rsp_t    want_q [$];
  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned real_items   = 0;
  int unsigned full_seen    = 0;
  int unsigned bad_seen     = 0;
  int unsigned hits_seen    = 0;
  bit          idling       = 1'b1;
  int unsigned stall_left   = 0;
  int unsigned quiet        = 0;

  function automatic void walk_char(op_e op, logic [7:0] ch);
    int unsigned slot;
    int unsigned nxt;
    if (walk_err != ST_OK) return;
    if (ch < CHAR_A || ch > CHAR_Z) begin
      walk_err = ST_BADCHAR;
      return;
    end
    if (walk_miss) return;
    slot = walk_node * ALPHABET + int'(ch - CHAR_A);
    nxt  = 32'(kid_tbl[slot]);
    if (nxt == 0) begin
      if (op != OP_INSERT) begin
        walk_miss = 1'b1;
        return;
      end
      if (pool_used >= NODE_COUNT) begin
        walk_err = ST_FULL;
        return;
      end
      nxt = pool_used;
      pool_used++;
      kid_tbl[slot] = NODE_W'(nxt);
    end
    walk_node = nxt;
  endfunction

  // Returns 1 when the request ends a word; rsp then holds the expected result.
  function automatic bit apply_req(in_req_t r, output out_rsp_t rsp);
    bit clean;
    rsp = '0;
    if (!r.no_char) walk_char(r.op, r.char_byte);
    if (!r.last) return 1'b0;
    clean = (walk_err == ST_OK) && !walk_miss;
    case (r.op)
      OP_INSERT: begin
        if (walk_err == ST_OK) word_end[walk_node] = 1'b1;
      end
      OP_SEARCH: begin
        rsp.found = clean && word_end[walk_node];
      end
      OP_REMOVE: begin
        if (clean) word_end[walk_node] = 1'b0;
      end
      default: begin
        rsp.found = clean;
      end
    endcase
    rsp.status = walk_err;
    walk_node  = 0;
    walk_miss  = 1'b0;
    walk_err   = ST_OK;
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(op_e op, logic [7:0] ch, logic nc, logic lst);
    in_req_t  r;
    out_rsp_t rsp;
    int unsigned gap;
    r.op        = op;
    r.char_byte = ch;
    r.no_char   = nc;
    r.last      = lst;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    if (apply_req(r, rsp)) want_q.push_back(rsp);
    if (!nc || lst) real_items++;
    @(negedge clk_i);
  endtask

  task automatic send_word(op_e op, string w);
    if (w.len() == 0) begin
      send_req(op, 8'h00, 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < w.len(); i++)
        send_req(op, w[i], 1'b0, i == w.len() - 1);
    end
  endtask

  // Sender holds off until every pending result is back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) return OP_INSERT;
    if (r < 13) return OP_SEARCH;
    if (r < 16) return OP_REMOVE;
    return OP_PREFIX;
  endfunction

  // Mostly letters from a narrow range so searches hit; now and then any byte.
  function automatic logic [7:0] pick_char(int unsigned span);
    if ($urandom_range(0, 39) == 0) return 8'($urandom_range(0, 255));
    return 8'(CHAR_A + $urandom_range(0, span - 1));
  endfunction

  task automatic send_random_word(int unsigned span, int unsigned max_len);
    int unsigned len;
    op_e         op;
    op_e         step_op;
    bit          tail_nc;
    len = $urandom_range(0, max_len);
    op  = pick_op();
    if (len == 0) begin
      send_req(op, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      tail_nc = ($urandom_range(0, 14) == 0);
      for (int i = 0; i < len; i++) begin
        // stray no-character request in the middle of a word
        if ($urandom_range(0, 24) == 0)
          send_req(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b1, 1'b0);
        // broken sequence: a step under a different op
        step_op = ($urandom_range(0, 19) == 0) ? op_e'($urandom_range(0, 3)) : op;
        send_req(step_op, pick_char(span), 1'b0, (i == len - 1) && !tail_nc);
      end
      if (tail_nc) send_req(op, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
  endtask

  // Tests

  task automatic test_empty_word();
    send_word(OP_SEARCH, "");   // root not marked yet
    send_word(OP_PREFIX, "");   // empty path always exists
    send_word(OP_INSERT, "");
    send_word(OP_SEARCH, "");
    send_word(OP_REMOVE, "");
    send_word(OP_SEARCH, "");
  endtask

  task automatic test_word_ops();
    send_word(OP_INSERT, "az");
    send_word(OP_SEARCH, "az");
    send_word(OP_SEARCH, "a");  // prefix only, no end mark
    send_word(OP_PREFIX, "a");
    send_word(OP_PREFIX, "b");  // missing child
    send_word(OP_REMOVE, "az");
    send_word(OP_SEARCH, "az");
  endtask

  task automatic test_bad_chars();
    send_req(OP_INSERT, 8'hFF, 1'b0, 1'b1);
    // miss first, then an invalid byte still flags
    send_req(OP_SEARCH, "q", 1'b0, 1'b0);
    send_req(OP_SEARCH, 8'h00, 1'b0, 1'b1);
    // invalid byte just below 'a', later letters ignored
    send_req(OP_INSERT, 8'h60, 1'b0, 1'b0);
    send_req(OP_INSERT, "a", 1'b0, 1'b1);
    send_req(OP_PREFIX, 8'h7B, 1'b0, 1'b1);  // just above 'z'
    // mixed ops in one word, ended by a no-character request
    send_req(OP_INSERT, "c", 1'b0, 1'b0);
    send_req(OP_SEARCH, 8'h41, 1'b1, 1'b0);
    send_req(OP_PREFIX, 8'h80, 1'b1, 1'b1);
  endtask

  task automatic test_random_words(int unsigned n, int unsigned span, int unsigned max_len);
    int unsigned stop_at;
    stop_at = real_items + n;
    while (real_items < stop_at) send_random_word(span, max_len);
  endtask

  // Result side: random stall bursts.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result found=%0b status=%0d", $time,
                 out_rsp_o.found, out_rsp_o.status);
      end else begin
        want = want_q.pop_front();
        results_seen++;
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_BADCHAR) bad_seen++;
        if (want.found) hits_seen++;
        if (out_rsp_o.found !== want.found) begin
          errors++;
          $display("%0t: found mismatch: expected %0b, actual %0b", $time,
                   want.found, out_rsp_o.found);
        end
        if (out_rsp_o.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   want.status, out_rsp_o.status);
        end
      end
    end
  end

  // Watchdog on consecutive cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("%0t: watchdog: no handshake in %0d cycles", $time, quiet);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_word();
    test_word_ops();
    test_bad_chars();
    test_random_words(180, 4, 5);
    wait_drained();
    test_random_words(170, 26, 8);
    idling = 1'b0;
    test_random_words(300, 6, 6);

    in_valid_i <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("Covered %0d requests, %0d results: %0d hits, %0d pool full, %0d bad char.",
             real_items, results_seen, hits_seen, full_seen, bad_seen);
    $display("Node pool ended at %0d of %0d nodes.", pool_used, NODE_COUNT);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
src/lte_pkg.sv
src/lte_front.sv
src/lte_queue.sv
src/lte_back.sv
src/lowercase_trie_engine_top.sv
src/lte_checker.sv
tb/sv/tb.sv
